// ===== hdl/pidci_pkg.sv =====
// ----------------------------------------------------------------------------
// pidci_pkg: shared types, constants and control store
// Beat formats, configuration, datapath widths and the microprogram of the
// clamped-integral PID regulator.
// ----------------------------------------------------------------------------
package pidci_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int SPLIT     = 24;               // integral split for the I product
  localparam int ACC_W     = 48;               // integrator width
  localparam int MUL_W     = 33;               // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 72;               // output accumulator
  localparam int DIV_W     = 33 + FRAC_BITS;   // preset dividend / quotient bits
  localparam int QUO_W     = (DIV_W > ACC_W + 1) ? DIV_W : ACC_W + 1;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int PC_W      = 4;
  localparam int REG_IDX_W = 2;
  localparam int DATA_W    = 32;

  localparam logic [ACC_W-1:0] INT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] INT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_P_GAIN    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_I_GAIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_D_GAIN    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ERROR = 2'd3;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_EDT  = 3'd1;
  localparam logic [2:0] MUL_PE   = 3'd2;
  localparam logic [2:0] MUL_DS   = 3'd3;
  localparam logic [2:0] MUL_ILO  = 3'd4;
  localparam logic [2:0] MUL_IHI  = 3'd5;

  // datapath operations
  localparam logic [3:0] ALU_NONE       = 4'd0;
  localparam logic [3:0] ALU_ERR        = 4'd1;
  localparam logic [3:0] ALU_INT_UPD    = 4'd2;
  localparam logic [3:0] ALU_ACC_LOAD   = 4'd3;
  localparam logic [3:0] ALU_ACC_ADD    = 4'd4;
  localparam logic [3:0] ALU_ACC_ADD_HI = 4'd5;
  localparam logic [3:0] ALU_DIV_INIT   = 4'd6;
  localparam logic [3:0] ALU_DIV_STEP   = 4'd7;
  localparam logic [3:0] ALU_PRE_LOAD   = 4'd8;

  // jump conditions
  localparam logic [1:0] JMP_NONE      = 2'd0;
  localparam logic [1:0] JMP_PRESET    = 2'd1;
  localparam logic [1:0] JMP_GAIN_ZERO = 2'd2;
  localparam logic [1:0] JMP_DIV_BUSY  = 2'd3;

  // microprogram addresses
  localparam logic [PC_W-1:0] ST_ERR      = 4'd0;
  localparam logic [PC_W-1:0] ST_MUL_EDT  = 4'd1;
  localparam logic [PC_W-1:0] ST_INT      = 4'd2;
  localparam logic [PC_W-1:0] ST_P        = 4'd3;
  localparam logic [PC_W-1:0] ST_D        = 4'd4;
  localparam logic [PC_W-1:0] ST_ILO      = 4'd5;
  localparam logic [PC_W-1:0] ST_IHI      = 4'd6;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd7;
  localparam logic [PC_W-1:0] ST_PRE_INIT = 4'd8;
  localparam logic [PC_W-1:0] ST_PRE_DIV  = 4'd9;
  localparam logic [PC_W-1:0] ST_PRE_LOAD = 4'd10;
  localparam logic [PC_W-1:0] ST_END      = 4'd11;

  typedef struct packed {
    logic               command;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic        [31:0] time_step;
    logic signed [31:0] error_slope;
    logic signed [31:0] preset_position;
    logic signed [31:0] preset_offset;
  } item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               error_clamped;
  } result_t;

  typedef struct packed {
    logic signed [31:0] p_gain;
    logic signed [31:0] i_gain;
    logic signed [31:0] d_gain;
    logic        [30:0] max_error;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic [3:0]      alu_op;
    logic [1:0]      jump;
    logic [PC_W-1:0] target;
    logic            last;
    logic            emit;
  } uword_t;

  typedef struct packed {
    logic preset;
    logic gain_zero;
    logic div_busy;
  } dp_flags_t;

  localparam uword_t UW_IDLE = '{MUL_NONE, ALU_NONE, JMP_NONE, ST_ERR, 1'b1, 1'b0};

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UW_IDLE;
    unique case (pc)
      ST_ERR:      w = '{MUL_NONE, ALU_ERR,        JMP_PRESET,    ST_PRE_INIT, 1'b0, 1'b0};
      ST_MUL_EDT:  w = '{MUL_EDT,  ALU_NONE,       JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_INT:      w = '{MUL_PE,   ALU_INT_UPD,    JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_P:        w = '{MUL_DS,   ALU_ACC_LOAD,   JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_D:        w = '{MUL_ILO,  ALU_ACC_ADD,    JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_ILO:      w = '{MUL_IHI,  ALU_ACC_ADD,    JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_IHI:      w = '{MUL_NONE, ALU_ACC_ADD_HI, JMP_NONE,      ST_ERR,      1'b0, 1'b0};
      ST_EMIT:     w = '{MUL_NONE, ALU_NONE,       JMP_NONE,      ST_ERR,      1'b1, 1'b1};
      ST_PRE_INIT: w = '{MUL_NONE, ALU_DIV_INIT,   JMP_GAIN_ZERO, ST_END,      1'b0, 1'b0};
      ST_PRE_DIV:  w = '{MUL_NONE, ALU_DIV_STEP,   JMP_DIV_BUSY,  ST_PRE_DIV,  1'b0, 1'b0};
      ST_PRE_LOAD: w = '{MUL_NONE, ALU_PRE_LOAD,   JMP_NONE,      ST_ERR,      1'b1, 1'b0};
      ST_END:      w = UW_IDLE;
      default:     w = UW_IDLE;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/pidci_seq.sv =====
// ----------------------------------------------------------------------------
// pidci_seq: microprogram sequencer
// Step counter over the control store with conditional jumps and a hold
// input that freezes the result step while the output is still occupied.
// ----------------------------------------------------------------------------
module pidci_seq
  import pidci_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      hold,
  input  dp_flags_t flags,
  output logic      busy,
  output uword_t    uw
);

  logic [PC_W-1:0] pc;
  uword_t          word;
  logic            taken;

  assign word = ucode(pc);
  assign uw   = busy ? word : UW_IDLE;

  always_comb begin
    case (word.jump)
      JMP_PRESET:    taken = flags.preset;
      JMP_GAIN_ZERO: taken = flags.gain_zero;
      JMP_DIV_BUSY:  taken = flags.div_busy;
      default:       taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= ST_ERR;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= ST_ERR;
    end else if (busy && !hold) begin
      if (word.last) begin
        busy <= 1'b0;
      end
      pc <= taken ? word.target : pc + 1'b1;
    end
  end

  a_hold_freezes: assert property (@(posedge clk) disable iff (rst)
    (busy && hold) |=> (busy && $stable(pc)))
    else $error("sequencer moved while held");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !hold && word.last) |=> !busy)
    else $error("sequencer still busy after last step");

endmodule

// ===== hdl/pidci_dp.sv =====
// ----------------------------------------------------------------------------
// pidci_dp: regulator datapath
// Item register, error limiter, shared 33x33 multiplier, integrator,
// output accumulator and a bit-serial restoring divider for the preset.
// ----------------------------------------------------------------------------
module pidci_dp
  import pidci_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  item_t     item,
  input  cfg_t      cfg,
  input  uword_t    uw,
  output dp_flags_t flags,
  output result_t   res
);

  item_t                     cur;
  logic signed [31:0]        err;
  logic                      clamped;
  logic signed [ACC_W-1:0]   integ;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic        [31:0]        rem;
  logic        [DIV_W-1:0]   dq;
  logic        [31:0]        dvs;
  logic                      neg;
  logic        [CNT_W-1:0]   cnt;

  logic signed [32:0]        e_raw;
  logic signed [32:0]        e_lim;
  logic signed [32:0]        e_sat;
  logic                      e_clip;
  logic signed [MUL_W-1:0]   ma;
  logic signed [MUL_W-1:0]   mb;
  logic signed [SUM_W-1:0]   prod_ext;
  logic signed [PROD_W-1:0]  isum;
  logic        [ACC_W-1:0]   integ_upd;
  logic        [32:0]        s;
  logic        [32:0]        s_mag;
  logic        [32:0]        trial;
  logic        [32:0]        diff;
  logic                      ge;
  logic        [QUO_W-1:0]   mag;
  logic        [ACC_W-1:0]   integ_pre;
  logic        [SUM_W-32:0]  upper;

  // error limit
  assign e_raw = {cur.measured[31], cur.measured} - {cur.setpoint[31], cur.setpoint};
  assign e_lim = {2'b00, cfg.max_error};

  always_comb begin
    e_sat  = e_raw;
    e_clip = 1'b0;
    if (e_raw > e_lim) begin
      e_sat  = e_lim;
      e_clip = 1'b1;
    end else if (e_raw < -e_lim) begin
      e_sat  = -e_lim;
      e_clip = 1'b1;
    end
  end

  // multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (uw.mul_sel)
      MUL_EDT: begin
        ma = {err[31], err};
        mb = {1'b0, cur.time_step};
      end
      MUL_PE: begin
        ma = {cfg.p_gain[31], cfg.p_gain};
        mb = {err[31], err};
      end
      MUL_DS: begin
        ma = {cfg.d_gain[31], cfg.d_gain};
        mb = {cur.error_slope[31], cur.error_slope};
      end
      MUL_ILO: begin
        ma = {cfg.i_gain[31], cfg.i_gain};
        mb = {{(MUL_W-SPLIT){1'b0}}, integ[SPLIT-1:0]};
      end
      MUL_IHI: begin
        ma = {cfg.i_gain[31], cfg.i_gain};
        mb = {{(MUL_W-(ACC_W-SPLIT)){integ[ACC_W-1]}}, integ[ACC_W-1:SPLIT]};
      end
      default: ;
    endcase
  end

  assign prod_ext = {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  // integrator: floored at zero, saturated at the top
  assign isum = (prod >>> FRAC_BITS) + $signed({{(PROD_W-ACC_W){integ[ACC_W-1]}}, integ});

  always_comb begin
    if (isum[PROD_W-1]) begin
      integ_upd = '0;
    end else if (|isum[PROD_W-2:ACC_W-1]) begin
      integ_upd = INT_MAX;
    end else begin
      integ_upd = isum[ACC_W-1:0];
    end
  end

  // preset divider: magnitudes, one quotient bit per step
  assign s     = {cur.preset_position[31], cur.preset_position}
               + {cur.preset_offset[31], cur.preset_offset};
  assign s_mag = s[32] ? 33'd0 - s : s;
  assign trial = {rem, dq[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};
  assign mag   = QUO_W'(dq);

  always_comb begin
    if (!neg) begin
      integ_pre = (mag > QUO_W'(INT_MAX)) ? INT_MAX : mag[ACC_W-1:0];
    end else begin
      integ_pre = (mag > QUO_W'(INT_MIN)) ? INT_MIN : ACC_W'(0) - mag[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item;
    end
    if (uw.mul_sel != MUL_NONE) begin
      prod <= ma * mb;
    end
    unique case (uw.alu_op)
      ALU_ERR: begin
        err     <= e_sat[31:0];
        clamped <= e_clip;
      end
      ALU_ACC_LOAD:   sum <= prod_ext >>> FRAC_BITS;
      ALU_ACC_ADD:    sum <= sum + (prod_ext >>> FRAC_BITS);
      ALU_ACC_ADD_HI: sum <= sum + (prod_ext <<< (SPLIT - FRAC_BITS));
      ALU_DIV_INIT: begin
        dq  <= {s_mag, {FRAC_BITS{1'b0}}};
        rem <= '0;
        dvs <= cfg.i_gain[31] ? 32'd0 - cfg.i_gain : cfg.i_gain;
        neg <= s[32] ^ cfg.i_gain[31];
        cnt <= CNT_W'(DIV_W - 1);
      end
      ALU_DIV_STEP: begin
        rem <= ge ? diff[31:0] : trial[31:0];
        dq  <= {dq[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
    if (rst) begin
      integ <= '0;
    end else if (uw.alu_op == ALU_INT_UPD) begin
      integ <= integ_upd;
    end else if (uw.alu_op == ALU_PRE_LOAD) begin
      integ <= integ_pre;
    end
  end

  assign flags.preset    = cur.command;
  assign flags.gain_zero = (cfg.i_gain == 32'sd0);
  assign flags.div_busy  = (cnt != '0);

  // saturate the accumulated drive to 32 bits
  assign upper = sum[SUM_W-1:31];

  always_comb begin
    if (&upper || ~|upper) begin
      res.drive = sum[31:0];
    end else begin
      res.drive = sum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    res.error_clamped = clamped;
  end

  a_integ_floor: assert property (@(posedge clk) disable iff (rst)
    (uw.alu_op == ALU_INT_UPD) |=> !integ[ACC_W-1])
    else $error("integrator negative after update");

endmodule

// ===== hdl/pid_clamped_integral.sv =====
// ----------------------------------------------------------------------------
// pid_clamped_integral: PID regulator with clamped error and integrator
// Signed fixed point regulator run by a small microprogram.
// ----------------------------------------------------------------------------
// Use:
//   item beats (item_valid/item_stall) carry either a regulate step
//   (command 0) or an integrator preset (command 1). A regulate beat gives
//   one result beat (result_valid/result_stall); a preset beat gives none.
//   Gains and the error limit are written on cfg_we/cfg_index/cfg_data while
//   the block is idle.
// Sequence:
//   Regulate: eight microprogram steps on one shared 33x33 multiplier, the
//   last of which loads the output register; the next item is taken only
//   once the sequencer is idle again.
//   Preset: the restoring divider loop runs one quotient bit per step and
//   sets the length of a preset. With a zero integral gain the loop is
//   skipped and the integrator is left as it is.
// Reset clears the integrator, zeroes the gains and sets the error limit to
// its maximum. A stalled result is held in the output register; the next
// item is still taken, and its result step waits until the register drains.
// ----------------------------------------------------------------------------
module pid_clamped_integral
  import pidci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t      cfg;
  uword_t    uw;
  dp_flags_t flags;
  result_t   res;
  logic      busy;
  logic      accept;
  logic      hold;
  logic      emit_fire;

  assign item_stall = busy;
  assign accept     = item_valid && !busy;
  assign hold       = uw.emit && result_valid && result_stall;
  assign emit_fire  = uw.emit && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain    <= '0;
      cfg.i_gain    <= '0;
      cfg.d_gain    <= '0;
      cfg.max_error <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_GAIN:    cfg.p_gain    <= cfg_data;
        REG_I_GAIN:    cfg.i_gain    <= cfg_data;
        REG_D_GAIN:    cfg.d_gain    <= cfg_data;
        REG_MAX_ERROR: cfg.max_error <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  pidci_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hold  (hold),
    .flags (flags),
    .busy  (busy),
    .uw    (uw)
  );

  pidci_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .item  (item),
    .cfg   (cfg),
    .uw    (uw),
    .flags (flags),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
    if (emit_fire) begin
      result <= res;
    end
  end

  a_emit_regulate: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> (busy && !flags.preset))
    else $error("result beat from a preset item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (busy && item_stall))
    else $error("sequencer not started by item beat");

endmodule
